// File: rtl/rdiv_pkg.sv
// ----------------------------------------------------------------------------
// rdiv_pkg
// Shared types for the restoring divider cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rdiv_pkg;

  // Control that travels alongside the payload from one cell to the next
  typedef struct packed {
    logic valid;  // cell holds an item
    logic ovf;    // quotient overflow flagged at entry
  } cell_ctl_t;

endpackage : rdiv_pkg

`default_nettype wire

// File: rtl/rdiv_cell.sv
// ----------------------------------------------------------------------------
// rdiv_cell
// One restoring step: shift carry:acc:mq left, trial subtract, restore or keep.
// ----------------------------------------------------------------------------
`default_nettype none

module rdiv_cell #(
  parameter int WIDTH = 8
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // upstream side
  input  rdiv_pkg::cell_ctl_t     up_ctl_i,
  input  wire  [WIDTH-1:0]        up_acc_i,
  input  wire  [WIDTH-1:0]        up_mq_i,
  input  wire  [WIDTH-1:0]        up_dvs_i,
  output logic                    up_ready_o,
  // downstream side
  output rdiv_pkg::cell_ctl_t     dn_ctl_o,
  output logic [WIDTH-1:0]        dn_acc_o,
  output logic [WIDTH-1:0]        dn_mq_o,
  output logic [WIDTH-1:0]        dn_dvs_o,
  input  wire                     dn_ready_i
);

  rdiv_pkg::cell_ctl_t ctl_q, ctl_d;
  logic [WIDTH-1:0]    acc_q, acc_d;
  logic [WIDTH-1:0]    mq_q, mq_d;
  logic [WIDTH-1:0]    dvs_q;
  logic [WIDTH:0]      cacc;
  logic [WIDTH:0]      diff;

  // cell takes a new item when empty or when its item moves on
  assign up_ready_o = !ctl_q.valid || dn_ready_i;

  // trial subtraction on the shifted carry:acc
  always_comb begin
    cacc = {up_acc_i, up_mq_i[WIDTH-1]};
    diff = cacc - {1'b0, up_dvs_i};
    if (cacc >= {1'b0, up_dvs_i}) begin
      acc_d = diff[WIDTH-1:0];
      mq_d  = {up_mq_i[WIDTH-2:0], 1'b1};
    end else begin
      acc_d = cacc[WIDTH-1:0];
      mq_d  = {up_mq_i[WIDTH-2:0], 1'b0};
    end
    ctl_d = up_ready_o ? up_ctl_i : ctl_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (up_ready_o) begin
      acc_q <= acc_d;
      mq_q  <= mq_d;
      dvs_q <= up_dvs_i;
    end
  end

  assign dn_ctl_o = ctl_q;
  assign dn_acc_o = acc_q;
  assign dn_mq_o  = mq_q;
  assign dn_dvs_o = dvs_q;

endmodule : rdiv_cell

`default_nettype wire

// File: rtl/restoring_divider_16_by_8.sv
// Each accepted input item passes through the WIDTH cell registers before its result appears on m_axis.
// Throughput: one item per cycle while m_axis is not stalled; each of the WIDTH cells holds one item.
// A stall on m_axis backs up through a per-cell ready chain, empty cells fill.
// Reset (rst_ni low, asynchronous) empties every cell; payload is not reset.
// ----------------------------------------------------------------------------
// restoring_divider_16_by_8
// Pipelined restoring divider, 2*WIDTH by WIDTH bits, one cell per step.
// ----------------------------------------------------------------------------
`default_nettype none

module restoring_divider_16_by_8 #(
  parameter int WIDTH = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // input items
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [2*WIDTH-1:0] dividend, [3*WIDTH-1:2*WIDTH] divisor, zero padding above
  input  wire  [((3*WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  // result items
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // [WIDTH-1:0] quotient, [2*WIDTH-1:WIDTH] remainder, zero padding above
  output logic [((2*WIDTH+7)/8)*8-1:0]         m_axis_tdata,
  // [0] overflow
  output logic                                 m_axis_tuser
);

  localparam int OutW = ((2*WIDTH+7)/8)*8;

  rdiv_pkg::cell_ctl_t ctl   [WIDTH+1];
  logic [WIDTH-1:0]    acc   [WIDTH+1];
  logic [WIDTH-1:0]    mq    [WIDTH+1];
  logic [WIDTH-1:0]    dvs   [WIDTH+1];
  logic                ready [WIDTH+1];

  // entry: split the dividend and flag quotient overflow
  always_comb begin
    acc[0]       = s_axis_tdata[2*WIDTH-1:WIDTH];
    mq[0]        = s_axis_tdata[WIDTH-1:0];
    dvs[0]       = s_axis_tdata[3*WIDTH-1:2*WIDTH];
    ctl[0].valid = s_axis_tvalid;
    ctl[0].ovf   = (s_axis_tdata[3*WIDTH-1:2*WIDTH] <= s_axis_tdata[2*WIDTH-1:WIDTH]);
  end

  assign s_axis_tready = ready[0];
  assign ready[WIDTH]  = m_axis_tready;

  // chain of step cells
  for (genvar g = 0; g < WIDTH; g++) begin : g_cell
    rdiv_cell #(.WIDTH(WIDTH)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_ctl_i   (ctl[g]),
      .up_acc_i   (acc[g]),
      .up_mq_i    (mq[g]),
      .up_dvs_i   (dvs[g]),
      .up_ready_o (ready[g]),
      .dn_ctl_o   (ctl[g+1]),
      .dn_acc_o   (acc[g+1]),
      .dn_mq_o    (mq[g+1]),
      .dn_dvs_o   (dvs[g+1]),
      .dn_ready_i (ready[g+1])
    );
  end

  // result: zero quotient and remainder on overflow
  always_comb begin
    m_axis_tvalid = ctl[WIDTH].valid;
    m_axis_tuser  = ctl[WIDTH].ovf;
    if (ctl[WIDTH].ovf) begin
      m_axis_tdata = '0;
    end else begin
      m_axis_tdata = OutW'({acc[WIDTH], mq[WIDTH]});
    end
  end

  // divisor copy leaves the last cell unused
  logic unused_dvs;
  assign unused_dvs = ^dvs[WIDTH];

endmodule : restoring_divider_16_by_8

`default_nettype wire

// File: rtl/rdiv_checker.sv
// ----------------------------------------------------------------------------
// rdiv_checker
// Port-level checks on the divider's result and input channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdiv_checker #(
  parameter int WIDTH = 8
) (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid,
  input wire                          s_axis_tready,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [((2*WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  input wire                          m_axis_tuser
);

  // a stalled result item stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // an overflow result carries zero quotient and remainder
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("overflow result not zero");

  // no result item in the cycle after reset was seen
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result offered after reset");

  // a free output means the chain can take an item
  a_ready_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with output free");

  logic unused_in;
  assign unused_in = s_axis_tvalid;

endmodule : rdiv_checker

bind restoring_divider_16_by_8 rdiv_checker #(.WIDTH(WIDTH)) u_rdiv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pipelined 16 by 8 restoring divider.
// A queue of division items feeds a stream driver. Each accepted item is
// divided by a local restoring-division model and the result is queued.
// A stream monitor checks every result item against the oldest queued
// quotient, remainder and overflow flag. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH      = 8;
  localparam int IN_BITS    = ((3*WIDTH+7)/8)*8;
  localparam int OUT_BITS   = ((2*WIDTH+7)/8)*8;
  localparam int N_RANDOM   = 1600;
  localparam int CALM_TAIL  = 150;    // final items sent with no idling
  localparam int STUCK_MAX  = 5000;   // cycles with no item moving
  localparam int PIPE_DEPTH = WIDTH;

  // One division to send; hold_back makes the sender wait for an empty pipe
  typedef struct packed {
    logic             hold_back;
    logic [2*WIDTH-1:0] dividend;
    logic [WIDTH-1:0]   divisor;
  } div_item_t;

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             overflow;
  } div_result_t;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  // [15:0] dividend, [23:16] divisor
  logic [IN_BITS-1:0]  s_axis_tdata = '0;
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [7:0] quotient, [15:8] remainder
  wire  [OUT_BITS-1:0] m_axis_tdata;
  // [0] overflow
  wire                 m_axis_tuser;

  div_item_t   pending_divisions[$];
  div_result_t expected_quot_rem[$];
  div_item_t   in_flight;
  int          src_gap    = 0;
  int          sink_gap   = 0;
  int          stuck_cnt  = 0;
  int          mismatches = 0;

  restoring_divider_16_by_8 #(
    .WIDTH(WIDTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Restoring division: shift carry:acc:mq, trial subtract, restore on borrow
  function automatic div_result_t divide_restoring(input logic [2*WIDTH-1:0] dividend,
                                                   input logic [WIDTH-1:0] divisor);
    div_result_t     res;
    logic [WIDTH-1:0] acc;
    logic [WIDTH-1:0] mq;
    logic [WIDTH:0]   trial;
    int               step;
    res = '0;
    acc = dividend[2*WIDTH-1:WIDTH];
    mq  = dividend[WIDTH-1:0];
    // quotient would not fit; covers a zero divisor too
    if (divisor <= acc) begin
      res.overflow = 1'b1;
      return res;
    end
    for (step = 0; step < WIDTH; step++) begin
      trial = {acc, mq[WIDTH-1]};
      mq    = mq << 1;
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
        mq[0] = 1'b1;
      end
      acc = trial[WIDTH-1:0];
    end
    res.quotient  = mq;
    res.remainder = acc;
    return res;
  endfunction

  function automatic bit in_calm_tail();
    return pending_divisions.size() < CALM_TAIL;
  endfunction

  task automatic queue_division(input logic [2*WIDTH-1:0] dividend,
                                input logic [WIDTH-1:0] divisor, input bit hold_back);
    div_item_t item;
    item.hold_back = hold_back;
    item.dividend  = dividend;
    item.divisor   = divisor;
    pending_divisions.push_back(item);
  endtask

  // Sender: records the prediction on acceptance, then loads, idles or holds
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_quot_rem.push_back(divide_restoring(in_flight.dividend, in_flight.divisor));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_divisions.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (pending_divisions[0].hold_back && expected_quot_rem.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!in_calm_tail() && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 3);
          s_axis_tvalid <= 1'b0;
        end else begin
          in_flight = pending_divisions.pop_front();
          s_axis_tdata  <= IN_BITS'({in_flight.divisor, in_flight.dividend});
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // Receiver: checks each result item, then picks the next ready level
  always @(posedge clk_i) begin
    div_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_quot_rem.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none expected: q=%0h r=%0h ovf=%0b", $time,
                   m_axis_tdata[WIDTH-1:0], m_axis_tdata[2*WIDTH-1:WIDTH], m_axis_tuser);
        end else begin
          want = expected_quot_rem.pop_front();
          if (m_axis_tdata[WIDTH-1:0] !== want.quotient) begin
            mismatches++;
            $display("%0t: quotient expected %0h actual %0h", $time, want.quotient,
                     m_axis_tdata[WIDTH-1:0]);
          end
          if (m_axis_tdata[2*WIDTH-1:WIDTH] !== want.remainder) begin
            mismatches++;
            $display("%0t: remainder expected %0h actual %0h", $time, want.remainder,
                     m_axis_tdata[2*WIDTH-1:WIDTH]);
          end
          if (m_axis_tuser !== want.overflow) begin
            mismatches++;
            $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                     m_axis_tuser);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (!in_calm_tail() && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles where no item moves on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck_cnt = 0;
      else
        stuck_cnt++;
      if (stuck_cnt >= STUCK_MAX) begin
        $display("%0t: no item moved for %0d cycles", $time, STUCK_MAX);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int          idx;
    logic [7:0]  dvs;
    logic [7:0]  upper;
    // directed: zero divisor, overflow boundary, extreme quotients
    queue_division(16'h0000, 8'h00, 1'b0);
    queue_division(16'hFFFF, 8'h00, 1'b0);
    queue_division(16'h00FF, 8'h00, 1'b0);
    queue_division(16'hFFFF, 8'hFF, 1'b0);
    queue_division(16'hFEFF, 8'hFF, 1'b0);
    queue_division(16'hFE00, 8'hFF, 1'b0);
    queue_division(16'h0000, 8'h01, 1'b0);
    queue_division(16'h00FF, 8'h01, 1'b0);
    queue_division(16'h0100, 8'h01, 1'b0);
    queue_division(16'h0001, 8'hFF, 1'b0);
    queue_division(16'h1234, 8'h12, 1'b0);
    queue_division(16'h1234, 8'h13, 1'b0);
    queue_division(16'h11FF, 8'h12, 1'b0);
    queue_division(16'h7FFF, 8'h80, 1'b0);
    queue_division(16'h8000, 8'h80, 1'b0);
    queue_division(16'h8000, 8'h81, 1'b0);
    queue_division(16'h5555, 8'hAA, 1'b0);
    queue_division(16'hAAAA, 8'hAB, 1'b0);
    queue_division(16'h0000, 8'hFF, 1'b0);
    queue_division(16'h7F80, 8'hFF, 1'b0);
    queue_division(16'h0003, 8'h02, 1'b0);
    queue_division(16'h00FE, 8'h02, 1'b0);
    // random: mostly in-range divisions, some raw and some zero divisors
    for (idx = 0; idx < N_RANDOM; idx++) begin
      case ($urandom_range(0, 9))
        0, 1: queue_division(16'($urandom), 8'($urandom), idx % 500 == 250);
        2:    queue_division(16'($urandom), 8'h00, idx % 500 == 250);
        default: begin
          dvs   = 8'($urandom_range(1, 255));
          upper = 8'($urandom_range(0, dvs - 1));
          queue_division({upper, 8'($urandom)}, dvs, idx % 500 == 250);
        end
      endcase
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_divisions.size() != 0 || s_axis_tvalid || expected_quot_rem.size() != 0);
    repeat (4 * PIPE_DEPTH) @(negedge clk_i);

    if (expected_quot_rem.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, expected_quot_rem.size());
    end
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule : tb

`default_nettype wire
